// ===== hdl/float32_to_half_converter_core_macros.svh =====
// Assertion macros shared by the float32 to half converter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef FLOAT32_TO_HALF_CONVERTER_CORE_MACROS_SVH
`define FLOAT32_TO_HALF_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define F2H_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while reset is low.
`define F2H_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/f2h_pkg.sv =====
// Types and constants for the float32 to half converter.
// No dependencies; used by the interfaces, f2h_convert, the core and the bench.
`timescale 1ns / 1ps

package f2h_pkg;

   typedef logic [31:0] single_type;
   typedef logic [15:0] half_type;

   localparam int SingleMantWidth = 23;
   localparam int HalfMantWidth   = 10;
   localparam int DropWidth       = SingleMantWidth - HalfMantWidth;

   // Biased single exponent thresholds.
   localparam logic [7:0] SingleExpAllOnes = 8'hFF;
   localparam logic [7:0] OverflowExpMax   = 8'd142;  // above this: infinity
   localparam logic [7:0] NormalExpMin     = 8'd113;  // half normal range
   localparam logic [7:0] SubnormExpMin    = 8'd103;  // half subnormal range
   localparam logic [7:0] ExpRebias        = 8'd112;  // 127 - 15

   localparam logic [4:0] HalfExpAllOnes   = 5'h1F;

endpackage

// ===== hdl/f2h_if.sv =====
// Valid/ready channel interfaces for the float32 input and half result.
// Depends on f2h_pkg.
`timescale 1ns / 1ps

interface f2h_req_if;
   import f2h_pkg::*;

   logic       valid;
   logic       ready;
   single_type single_bits;

   modport source (output valid, output single_bits, input ready);
   modport sink   (input valid, input single_bits, output ready);
endinterface

interface f2h_rsp_if;
   import f2h_pkg::*;

   logic     valid;
   logic     ready;
   half_type half_bits;

   modport source (output valid, output half_bits, input ready);
   modport sink   (input valid, input half_bits, output ready);
endinterface

// ===== hdl/f2h_pipe_reg.sv =====
// One valid/ready register stage; holds its word until the next stage takes it.
// No package dependencies.
`timescale 1ns / 1ps

module f2h_pipe_reg #(
   parameter int Width = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [Width-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Width-1:0] out_data
);

   logic             valid_ff, valid_in;
   logic [Width-1:0] data_ff, data_in;

   // The stage can load whenever it is empty or its word leaves this cycle.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/f2h_convert.sv =====
// Combinational binary32 to binary16 conversion of one word.
// Depends on f2h_pkg.
`timescale 1ns / 1ps

module f2h_convert (
   input  f2h_pkg::single_type single_bits,
   output f2h_pkg::half_type   half_bits
);
   import f2h_pkg::*;

   logic                       sign;
   logic [7:0]                 exp;
   logic [SingleMantWidth-1:0] mant;
   logic [HalfMantWidth-1:0]   nan_mant;
   logic [4:0]                 norm_exp;
   logic                       norm_round;
   logic [14:0]                norm_mag;
   logic [7:0]                 sub_shift;
   logic [SingleMantWidth:0]   sub_full;
   logic [SingleMantWidth:0]   sub_shifted;
   logic [HalfMantWidth:0]     sub_mag;

   assign sign = single_bits[31];
   assign exp  = single_bits[30:23];
   assign mant = single_bits[SingleMantWidth-1:0];

   // A NaN keeps its top payload bits but must not collapse to infinity.
   assign nan_mant = (mant[SingleMantWidth-1:DropWidth] != '0)
                   ? mant[SingleMantWidth-1:DropWidth] : HalfMantWidth'(1);

   // Normal range: round to nearest even. The carry runs straight into the
   // exponent field, so a mantissa overflow at the top exponent gives infinity.
   assign norm_exp   = 5'(exp - ExpRebias);
   assign norm_round = mant[DropWidth-1]
                     && ((mant[DropWidth-2:0] != '0) || mant[DropWidth]);
   assign norm_mag   = {norm_exp, mant[SingleMantWidth-1:DropWidth]} + 15'(norm_round);

   // Subnormal range: the shift leaves the first dropped bit at bit 0, and
   // that bit alone decides the round-up. A carry to 0x400 is the smallest normal.
   assign sub_shift   = (NormalExpMin - exp) + 8'(DropWidth - 1);
   assign sub_full    = {1'b1, mant};
   assign sub_shifted = sub_full >> sub_shift[4:0];
   assign sub_mag     = sub_shifted[HalfMantWidth+1:1] + (HalfMantWidth+1)'(sub_shifted[0]);

   always_comb begin
      if (single_bits[30:0] == '0) begin
         half_bits = {sign, 15'd0};
      end else if (exp == SingleExpAllOnes) begin
         if (mant == '0) begin
            half_bits = {sign, HalfExpAllOnes, {HalfMantWidth{1'b0}}};
         end else begin
            half_bits = {sign, HalfExpAllOnes, nan_mant};
         end
      end else if (exp > OverflowExpMax) begin
         half_bits = {sign, HalfExpAllOnes, {HalfMantWidth{1'b0}}};
      end else if (exp >= NormalExpMin) begin
         half_bits = {sign, norm_mag};
      end else if (exp >= SubnormExpMin) begin
         half_bits = {sign, 4'd0, sub_mag};
      end else begin
         half_bits = {sign, 15'd0};
      end
   end

endmodule

// ===== hdl/float32_to_half_converter_core.sv =====
// Float32 to half converter: an input register, the conversion logic and a result
// register. A transfer can be taken on every clock while the result side keeps up;
// when a result waits at the output, the block takes at most one more word and then
// holds req_ready low. Each word passes the input register and then the result
// register and comes out in order, one result per input. Throughput is one word per
// clock while the result side keeps up. Overflow gives infinity, the normal range
// rounds to nearest even, the half subnormal range rounds half up, NaN stays NaN.
`timescale 1ns / 1ps

`include "float32_to_half_converter_core_macros.svh"

module float32_to_half_converter_core (
   input  logic         clock,
   input  logic         reset,
   f2h_req_if.sink      req_bus,
   f2h_rsp_if.source    rsp_bus
);
   import f2h_pkg::*;

   logic       in_valid;
   logic       in_ready;
   single_type in_word;
   half_type   conv_word;
   logic       in_move;
   logic       in_sign;
   logic       in_is_nan;
   logic       rsp_sign;
   logic       rsp_is_nan;
   logic       pipe_empty;

   f2h_pipe_reg #(.Width(32)) u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_bus.single_bits),
      .out_valid (in_valid),
      .out_ready (in_ready),
      .out_data  (in_word)
   );

   f2h_convert u_convert (
      .single_bits (in_word),
      .half_bits   (conv_word)
   );

   f2h_pipe_reg #(.Width(16)) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_ready  (in_ready),
      .in_data   (conv_word),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_bus.half_bits)
   );

   assign in_move    = in_valid && in_ready;
   assign in_sign    = in_word[31];
   assign in_is_nan  = (in_word[30:23] == SingleExpAllOnes) && (in_word[22:0] != '0);
   assign rsp_sign   = rsp_bus.half_bits[15];
   assign rsp_is_nan = (rsp_bus.half_bits[14:10] == HalfExpAllOnes)
                     && (rsp_bus.half_bits[9:0] != '0);
   assign pipe_empty = !in_valid && !rsp_bus.valid;

   // A word leaving the input register must appear as a result next cycle.
   `F2H_ASSERT_NEXT(a_stage_move, clock, reset, in_move, rsp_bus.valid, "word lost between stages")

   // The sign bit always survives the conversion.
   `F2H_ASSERT_NEXT(a_sign_kept, clock, reset, in_move, rsp_sign == $past(in_sign), "sign changed")

   // A NaN input stays a NaN.
   `F2H_ASSERT_NEXT(a_nan_kept, clock, reset, in_move && in_is_nan, rsp_is_nan, "NaN lost")

   // With both stages empty the block must take input.
   `F2H_ASSERT_SAME(a_empty_ready, clock, reset, pipe_empty, req_bus.ready, "empty pipe not ready")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the float32 to half converter core: drives binary32
// words over the request channel and checks every half result against a predictor.
// Depends on f2h_pkg, the f2h_req_if/f2h_rsp_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_top;
   import f2h_pkg::*;

   logic clock;
   logic reset;

   f2h_req_if req_ch ();
   f2h_rsp_if rsp_ch ();

   float32_to_half_converter_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   half_type expected_halves[$];
   int       error_count = 0;
   int       words_sent = 0;
   int       halves_checked = 0;
   bit       send_idle = 1'b1;
   bit       recv_idle = 1'b1;

   // Expected binary16 encoding of one binary32 word.
   function automatic half_type half_of_single(single_type word);
      logic        sgn;
      logic [7:0]  exp_field;
      logic [22:0] mant;
      logic [23:0] full;
      logic [10:0] hmant;
      logic [4:0]  hexp;
      int          shift;
      sgn       = word[31];
      exp_field = word[30:23];
      mant      = word[22:0];
      if (word[30:0] == '0)
         return {sgn, 15'd0};
      if (exp_field == SingleExpAllOnes) begin
         if (mant == '0)
            return {sgn, HalfExpAllOnes, 10'd0};
         // A NaN must stay a NaN even when its top payload bits are all zero.
         return {sgn, HalfExpAllOnes, (mant[22:13] != '0) ? mant[22:13] : 10'd1};
      end
      if (exp_field > OverflowExpMax)
         return {sgn, HalfExpAllOnes, 10'd0};
      if (exp_field >= NormalExpMin) begin
         hexp  = 5'(exp_field - ExpRebias);
         hmant = {1'b0, mant[22:13]};
         if (mant[12] && (mant[11:0] != '0 || mant[13]))
            hmant = hmant + 11'd1;
         if (hmant[10]) begin
            hexp = hexp + 5'd1;
            if (hexp == HalfExpAllOnes)
               return {sgn, HalfExpAllOnes, 10'd0};
         end
         return {sgn, hexp, hmant[9:0]};
      end
      if (exp_field >= SubnormExpMin) begin
         // Subnormal range rounds half up: only the first dropped bit counts.
         shift = int'(NormalExpMin) - int'(exp_field);
         full  = {1'b1, mant};
         hmant = 11'(full >> (shift + DropWidth));
         if (full[shift + DropWidth - 1])
            hmant = hmant + 11'd1;
         return {sgn, 4'd0, hmant};
      end
      return {sgn, 15'd0};
   endfunction

   // Random word, weighted toward the exponent bands and the rounding boundaries.
   function automatic single_type random_single();
      logic        sgn;
      logic [7:0]  exp_field;
      logic [22:0] mant;
      int          pick;
      sgn  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 8)
         exp_field = 8'd0;
      else if (pick < 16)
         exp_field = 8'($urandom_range(1, int'(SubnormExpMin) - 1));
      else if (pick < 40)
         exp_field = 8'($urandom_range(int'(SubnormExpMin), int'(NormalExpMin) - 1));
      else if (pick < 75)
         exp_field = 8'($urandom_range(int'(NormalExpMin), int'(OverflowExpMax)));
      else if (pick < 85)
         exp_field = 8'($urandom_range(int'(OverflowExpMax) + 1, 254));
      else if (pick < 93)
         exp_field = SingleExpAllOnes;
      else
         return $urandom();
      pick = $urandom_range(0, 3);
      if (pick == 0)
         mant = 23'($urandom());
      else if (pick == 1)
         mant = {10'($urandom()), 13'h1000};
      else if (pick == 2)
         mant = {10'($urandom()), $urandom_range(0, 1) ? 13'h0FFF : 13'h1001};
      else
         mant = $urandom_range(0, 1) ? 23'h7FFFFF : {10'd0, 13'($urandom())};
      return {sgn, exp_field, mant};
   endfunction

   // Presents one word and returns at the edge where it is transferred.
   task automatic send_single(input single_type word);
      int gap;
      gap = send_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.single_bits <= word;
      do @(posedge clock); while (!req_ch.ready);
      expected_halves.push_back(half_of_single(word));
      words_sent++;
   endtask

   task automatic test_special_values();
      single_type words[$];
      words = '{
         32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
         32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h4780_0000,
         32'h7F7F_FFFF, 32'h477F_E000, 32'h477F_F000, 32'h3F80_0000,
         32'h3F80_1000, 32'h3F80_3000, 32'h3F80_1001, 32'h3880_0000,
         32'h387F_F000, 32'h3380_0000, 32'h3300_0000, 32'h0000_0001,
         32'h807F_FFFF, 32'h3800_0000, 32'h3420_0000, 32'hC700_0000
      };
      foreach (words[i])
         send_single(words[i]);
   endtask

   task automatic test_mixed_random(input int count);
      repeat (count)
         send_single(random_single());
   endtask

   // Fully random words with the sender idling but the receiver always ready.
   task automatic test_raw_words(input int count);
      recv_idle = 1'b0;
      repeat (count)
         send_single($urandom());
      recv_idle = 1'b1;
   endtask

   // Back-to-back transfers with no idling on either side.
   task automatic test_streaming(input int count);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      repeat (count)
         send_single(random_single());
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Result side: may hold ready low for a random stall before each transfer while recv_idle is set.
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = recv_idle ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      half_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_halves.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual half_bits=%h",
                     $time, rsp_ch.half_bits);
            error_count++;
         end else begin
            want = expected_halves.pop_front();
            halves_checked++;
            if (rsp_ch.half_bits !== want) begin
               $display("%0t: half_bits mismatch, expected %h, actual %h",
                        $time, want, rsp_ch.half_bits);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.single_bits <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_values();
      test_mixed_random(300);
      test_raw_words(100);
      test_streaming(100);

      req_ch.valid <= 1'b0;
      while (expected_halves.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      if (expected_halves.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_halves.size());
         error_count++;
      end

      $display("Converted %0d single words and checked %0d half results.",
               words_sent, halves_checked);
      $display("Covered zeros, infinities, NaNs, overflow, both rounding modes and underflow.");
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
